/* rtl/ethernet_protocol_class_counter_defines.svh */
// Assertion macros for the RTL file that checks its own logic.
`ifndef ETHERNET_PROTOCOL_CLASS_COUNTER_DEFINES_SVH
`define ETHERNET_PROTOCOL_CLASS_COUNTER_DEFINES_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define EPCC_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define EPCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define EPCC_ASSERT_SAME(label, clk, rst, ante, cons)
`define EPCC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/epcc_pkg.sv */
package epcc_pkg;

  // Sizes of the counter bank.
  localparam int NUM_CATEGORIES = 7;
  localparam int COUNT_WIDTH    = 64;
  localparam int CAT_W          = 3;
  localparam int POS_W          = 6;
  localparam int LEN_W          = POS_W + 1;

  // Packed stream widths.
  localparam int S_TDATA_W = 16;
  localparam int M_TDATA_W = 72;

  // Byte positions and length limits within a frame.
  localparam logic [POS_W-1:0] POS_SAT      = 6'd54;
  localparam logic [POS_W-1:0] POS_ETYPE_HI = 6'd12;
  localparam logic [POS_W-1:0] POS_ETYPE_LO = 6'd13;
  localparam logic [POS_W-1:0] POS_V6_NEXT  = 6'd20;
  localparam logic [POS_W-1:0] POS_V4_PROTO = 6'd23;
  localparam logic [LEN_W-1:0] ETH_MIN_LEN  = 7'd14;
  localparam logic [LEN_W-1:0] IPV4_MIN_LEN = 7'd34;
  localparam logic [LEN_W-1:0] IPV6_MIN_LEN = 7'd54;

  // Ethertype and protocol numbers.
  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_ARP  = 16'h0806;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
  localparam logic [7:0]  PROTO_ICMP   = 8'd1;
  localparam logic [7:0]  PROTO_TCP    = 8'd6;
  localparam logic [7:0]  PROTO_UDP    = 8'd17;
  localparam logic [7:0]  PROTO_ICMPV6 = 8'd58;

  // Request and reply kinds carried in tuser.
  localparam logic REQ_FRAME = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  typedef enum logic [CAT_W-1:0] {
    CAT_MISC     = 3'd0,
    CAT_ARP      = 3'd1,
    CAT_TCP      = 3'd2,
    CAT_UDP      = 3'd3,
    CAT_CTRL_MSG = 3'd4,
    CAT_V4_OTHER = 3'd5,
    CAT_V6_OTHER = 3'd6
  } category_t;

  // Access to the counter bank for one beat.
  typedef struct packed {
    logic             rd;
    logic             inc;
    logic [CAT_W-1:0] idx;
  } cnt_req_t;

endpackage

/* rtl/ethernet_protocol_class_counter.sv */
// Classifies received Ethernet frames by ethertype and L4 protocol into seven
// categories and keeps a 64-bit wrapping counter per category. Frame bytes
// enter one beat per byte (tuser low, tlast on the final byte); a beat with
// tuser high is a counter read and returns the counter chosen by its index.
// A taken beat waits in the input register until it can move on; its result is
// then loaded into the result register, offered from there, and leaves at an
// edge where tready is high. One beat is taken every cycle while the result
// side keeps up. Frame bytes other than the last produce no result and pass
// even while a result waits.
`include "ethernet_protocol_class_counter_defines.svh"

module ethernet_protocol_class_counter
  import epcc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,  // frame_byte[7:0], read_index[10:8], zeros
  input  logic                 s_axis_tlast,  // frame_last
  input  logic                 s_axis_tuser,  // req_type
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,  // category[2:0], count_value[66:3], zeros
  output logic                 m_axis_tuser   // reply_kind
);

  // Input register.
  logic             in_valid;
  logic             in_req;
  logic [7:0]       in_byte;
  logic             in_last;
  logic [CAT_W-1:0] in_idx;

  // Result register.
  logic                   out_valid;
  logic                   out_kind;
  logic [CAT_W-1:0]       out_cat;
  logic [COUNT_WIDTH-1:0] out_count;

  logic                   in_take;
  logic                   has_result;
  logic                   proc_fire;
  logic                   out_load;
  category_t              frame_cat;
  cnt_req_t               cnt_req;
  logic [COUNT_WIDTH-1:0] cnt_value;

  // A beat moves on when it yields no result or the result register frees up.
  always_comb begin
    has_result    = (in_req == REQ_READ) || in_last;
    proc_fire     = in_valid && (!has_result || !out_valid || m_axis_tready);
    out_load      = proc_fire && has_result;
    s_axis_tready = !in_valid || proc_fire;
    in_take       = s_axis_tvalid && s_axis_tready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_take) begin
      in_valid <= 1'b1;
    end else if (proc_fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_req  <= s_axis_tuser;
      in_byte <= s_axis_tdata[7:0];
      in_last <= s_axis_tlast;
      in_idx  <= s_axis_tdata[10:8];
    end
  end

  epcc_classify u_classify (
    .clk        (clk),
    .rst        (rst),
    .step       (proc_fire && (in_req == REQ_FRAME)),
    .frame_byte (in_byte),
    .frame_last (in_last),
    .category   (frame_cat)
  );

  // Counter access: a read at the request index, or an update at frame end.
  always_comb begin
    cnt_req.rd  = proc_fire && (in_req == REQ_READ);
    cnt_req.inc = proc_fire && (in_req == REQ_FRAME) && in_last;
    cnt_req.idx = (in_req == REQ_READ) ? in_idx : CAT_W'(frame_cat);
  end

  epcc_counters u_counters (
    .clk         (clk),
    .rst         (rst),
    .req         (cnt_req),
    .count_value (cnt_value)
  );

  // Result register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind  <= cnt_req.rd ? REQ_READ : REQ_FRAME;
      out_cat   <= cnt_req.idx;
      out_count <= cnt_value;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_kind;
  assign m_axis_tdata  = {{(M_TDATA_W - COUNT_WIDTH - CAT_W){1'b0}}, out_count, out_cat};

  // A new result only ever comes from a beat that was just processed.
  `EPCC_ASSERT_NEXT(a_load_source, clk, rst, !out_valid && !out_load, !m_axis_tvalid)
  // A read of the unused index returns zero.
  `EPCC_ASSERT_SAME(a_unused_idx_zero, clk, rst,
                    out_valid && (out_kind == REQ_READ) && (out_cat == 3'd7), out_count == '0)
  // A frame is never classified into the unused index.
  `EPCC_ASSERT_SAME(a_frame_cat_range, clk, rst,
                    out_valid && (out_kind == REQ_FRAME), out_cat != 3'd7)

endmodule

/* rtl/epcc_classify.sv */
module epcc_classify
  import epcc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  logic [7:0] frame_byte,
  input  logic      frame_last,
  output category_t category
);

  logic [POS_W-1:0] byte_position;
  logic [15:0]      ether_type;
  logic [7:0]       protocol_byte_v4;
  logic [7:0]       next_header_v6;

  logic [15:0]      ether_type_next;
  logic [7:0]       protocol_byte_v4_next;
  logic [7:0]       next_header_v6_next;
  logic [LEN_W-1:0] frame_len;

  // Header fields as they stand once this byte is captured.
  always_comb begin
    ether_type_next = ether_type;
    if (byte_position == POS_ETYPE_HI) begin
      ether_type_next = {frame_byte, ether_type[7:0]};
    end
    if (byte_position == POS_ETYPE_LO) begin
      ether_type_next = {ether_type[15:8], frame_byte};
    end
    next_header_v6_next = (byte_position == POS_V6_NEXT) ? frame_byte : next_header_v6;
    protocol_byte_v4_next = (byte_position == POS_V4_PROTO) ? frame_byte : protocol_byte_v4;
    frame_len = {1'b0, byte_position} + LEN_W'(1);
  end

  // Category of a frame ending on this byte.
  always_comb begin
    category = CAT_MISC;
    if (frame_len >= ETH_MIN_LEN) begin
      if (ether_type_next == ETYPE_ARP) begin
        category = CAT_ARP;
      end else if (ether_type_next == ETYPE_IPV4) begin
        if (frame_len >= IPV4_MIN_LEN) begin
          if (protocol_byte_v4_next == PROTO_TCP) begin
            category = CAT_TCP;
          end else if (protocol_byte_v4_next == PROTO_UDP) begin
            category = CAT_UDP;
          end else if (protocol_byte_v4_next == PROTO_ICMP) begin
            category = CAT_CTRL_MSG;
          end else begin
            category = CAT_V4_OTHER;
          end
        end
      end else if (ether_type_next == ETYPE_IPV6) begin
        category = CAT_V6_OTHER;
        if (frame_len >= IPV6_MIN_LEN) begin
          if (next_header_v6_next == PROTO_TCP) begin
            category = CAT_TCP;
          end else if (next_header_v6_next == PROTO_UDP) begin
            category = CAT_UDP;
          end else if (next_header_v6_next == PROTO_ICMPV6) begin
            category = CAT_CTRL_MSG;
          end
        end
      end
    end
  end

  // Frame capture state; cleared at the end of each frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      ether_type       <= '0;
      protocol_byte_v4 <= '0;
      next_header_v6   <= '0;
    end else if (step) begin
      if (frame_last) begin
        byte_position    <= '0;
        ether_type       <= '0;
        protocol_byte_v4 <= '0;
        next_header_v6   <= '0;
      end else begin
        ether_type       <= ether_type_next;
        protocol_byte_v4 <= protocol_byte_v4_next;
        next_header_v6   <= next_header_v6_next;
        if (byte_position < POS_SAT) begin
          byte_position <= byte_position + POS_W'(1);
        end
      end
    end
  end

endmodule

/* rtl/epcc_counters.sv */
module epcc_counters
  import epcc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  cnt_req_t               req,
  output logic [COUNT_WIDTH-1:0] count_value
);

  logic [COUNT_WIDTH-1:0] counters [NUM_CATEGORIES];
  logic                   idx_ok;
  logic [COUNT_WIDTH-1:0] cur_value;
  logic [COUNT_WIDTH-1:0] inc_value;

  // One read port; an index past the last category reads as zero.
  always_comb begin
    idx_ok    = 32'(req.idx) < NUM_CATEGORIES;
    cur_value = idx_ok ? counters[req.idx] : '0;
    inc_value = cur_value + COUNT_WIDTH'(1);
    count_value = req.inc ? inc_value : cur_value;
  end

  // Increment the addressed counter at the end of a frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CATEGORIES; i++) begin
        counters[i] <= '0;
      end
    end else if (req.inc && idx_ok) begin
      counters[req.idx] <= inc_value;
    end
  end

endmodule

/* test/tb_ethernet_protocol_class_counter.sv */
module tb_ethernet_protocol_class_counter;
  import epcc_pkg::*;

  // Predicts the classification and counter replies and checks them in order.
  class class_counter_scoreboard;
    typedef struct packed {
      logic             kind;
      logic [CAT_W-1:0] cat;
      logic [63:0]      count;
    } reply_t;

    reply_t           pending_replies[$];
    logic [POS_W-1:0] byte_pos;
    logic [15:0]      etype;
    logic [7:0]       v4_proto;
    logic [7:0]       v6_next;
    logic [63:0]      counts[NUM_CATEGORIES];
    int               mismatches;

    function new();
      byte_pos   = '0;
      etype      = '0;
      v4_proto   = '0;
      v6_next    = '0;
      mismatches = 0;
      for (int i = 0; i < NUM_CATEGORIES; i++) counts[i] = '0;
    endfunction

    // TCP and UDP share numbers across both IP versions; ICMP does not.
    function category_t l4_class(logic [7:0] proto, logic [7:0] icmp_proto,
                                 category_t fallback);
      if (proto == PROTO_TCP) return CAT_TCP;
      if (proto == PROTO_UDP) return CAT_UDP;
      if (proto == icmp_proto) return CAT_CTRL_MSG;
      return fallback;
    endfunction

    function category_t classify(logic [LEN_W-1:0] len);
      if (len < ETH_MIN_LEN) return CAT_MISC;
      case (etype)
        ETYPE_ARP: return CAT_ARP;
        ETYPE_IPV4: begin
          if (len < IPV4_MIN_LEN) return CAT_MISC;
          return l4_class(v4_proto, PROTO_ICMP, CAT_V4_OTHER);
        end
        ETYPE_IPV6: begin
          if (len < IPV6_MIN_LEN) return CAT_V6_OTHER;
          return l4_class(v6_next, PROTO_ICMPV6, CAT_V6_OTHER);
        end
        default: return CAT_MISC;
      endcase
    endfunction

    // Queues a read's reply, or tracks a frame byte and queues a reply at frame end.
    function void note_beat(logic req, logic [7:0] b, logic last, logic [CAT_W-1:0] idx);
      reply_t    r;
      category_t cat;
      if (req == REQ_READ) begin
        r.kind  = REQ_READ;
        r.cat   = idx;
        r.count = (idx < NUM_CATEGORIES) ? counts[idx] : 64'd0;
        pending_replies.push_back(r);
        return;
      end
      if (byte_pos == POS_ETYPE_HI) etype[15:8] = b;
      if (byte_pos == POS_ETYPE_LO) etype[7:0] = b;
      if (byte_pos == POS_V6_NEXT) v6_next = b;
      if (byte_pos == POS_V4_PROTO) v4_proto = b;
      if (!last) begin
        if (byte_pos < POS_SAT) byte_pos = byte_pos + 1'b1;
        return;
      end
      cat = classify({1'b0, byte_pos} + 1'b1);
      counts[cat] = counts[cat] + 64'd1;
      r.kind  = REQ_FRAME;
      r.cat   = cat;
      r.count = counts[cat];
      pending_replies.push_back(r);
      byte_pos = '0;
      etype    = '0;
      v4_proto = '0;
      v6_next  = '0;
    endfunction

    // Compares one accepted output beat with the oldest expected reply.
    function void check_reply(logic kind, logic [CAT_W-1:0] cat, logic [63:0] count);
      reply_t r;
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected reply kind=%0d category=%0d count=%0h",
                 $time, kind, cat, count);
        mismatches++;
        return;
      end
      r = pending_replies.pop_front();
      if (kind !== r.kind) begin
        $display("%0t: reply kind expected %0d actual %0d", $time, r.kind, kind);
        mismatches++;
      end
      if (cat !== r.cat) begin
        $display("%0t: category expected %0d actual %0d", $time, r.cat, cat);
        mismatches++;
      end
      if (count !== r.count) begin
        $display("%0t: count expected %0h actual %0h", $time, r.count, count);
        mismatches++;
      end
    endfunction

    function int outstanding();
      return pending_replies.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;  // frame_byte[7:0], read_index[10:8], zeros
  logic                 s_axis_tlast = 1'b0;  // frame_last
  logic                 s_axis_tuser = 1'b0;  // req_type
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;  // category[2:0], count_value[66:3], zeros
  logic                 m_axis_tuser;  // reply_kind

  class_counter_scoreboard sb;
  int beats_sent    = 0;
  int send_idle_pct = 26;
  int recv_idle_pct = 77;
  bit hold_pending  = 1'b0;

  ethernet_protocol_class_counter dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Watches both sides and feeds every accepted beat to the scoreboard.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_beat(s_axis_tuser, s_axis_tdata[7:0], s_axis_tlast, s_axis_tdata[10:8]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_reply(m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[66:3]);
      end
    end
  end

  // Result side: random stalls, plus one long hold-off when asked for.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one beat and returns at the edge where it is taken.
  task automatic push_beat(input logic req, input logic [7:0] b, input logic last,
                           input logic [2:0] idx);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'd0, idx, b};
    s_axis_tlast  <= last;
    s_axis_tuser  <= req;
    do @(posedge clk); while (!s_axis_tready);
    beats_sent++;
    // Swap the idling sides, then drop idling and stall the result side hard.
    if (beats_sent == 200) begin
      send_idle_pct = 77;
      recv_idle_pct = 26;
    end else if (beats_sent == 400) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_pending  = 1'b1;
    end
  endtask

  task automatic send_read(input logic [2:0] idx);
    push_beat(REQ_READ, 8'($urandom), 1'($urandom_range(1)), idx);
  endtask

  // Sends one frame with the header fields in place and random payload,
  // with counter reads slipped in between bytes now and then.
  task automatic send_frame(input int len, input logic [15:0] etype,
                            input logic [7:0] next_hdr, input logic [7:0] proto,
                            input int read_pct);
    logic [7:0] b;
    for (int p = 0; p < len; p++) begin
      b = 8'($urandom);
      if (p == 12) b = etype[15:8];
      if (p == 13) b = etype[7:0];
      if (p == 20) b = next_hdr;
      if (p == 23) b = proto;
      if (read_pct != 0 && $urandom_range(99) < read_pct) send_read(3'($urandom_range(7)));
      push_beat(REQ_FRAME, b, p == len - 1, 3'($urandom_range(7)));
    end
  endtask

  function automatic logic [7:0] pick_proto();
    case ($urandom_range(4))
      0: return PROTO_TCP;
      1: return PROTO_UDP;
      2: return PROTO_ICMP;
      3: return PROTO_ICMPV6;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_etype();
    case ($urandom_range(9))
      0, 1, 2: return ETYPE_IPV4;
      3:       return ETYPE_ARP;
      4, 5, 6: return ETYPE_IPV6;
      7:       return ETYPE_IPV6 ^ 16'(1 << $urandom_range(15));
      8:       return ETYPE_IPV4 ^ 16'(1 << $urandom_range(15));
      default: return 16'($urandom);
    endcase
  endfunction

  // Lengths cluster around the thresholds where the classification changes.
  function automatic int pick_len();
    case ($urandom_range(9))
      0, 1:    return $urandom_range(1, 13);
      2:       return $urandom_range(14, 20);
      3, 4:    return $urandom_range(32, 36);
      5, 6, 7: return $urandom_range(52, 56);
      8:       return $urandom_range(21, 31);
      default: return $urandom_range(57, 80);
    endcase
  endfunction

  // Reset, directed cases, random frames, then drain and report.
  initial begin
    sb = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Every counter reads zero after reset, and an index past the bank reads zero.
    for (int i = 0; i < 8; i++) send_read(3'(i));
    // A one-byte frame counts as other.
    push_beat(REQ_FRAME, 8'hFF, 1'b1, 3'd7);
    // The shortest frame that carries an ethertype.
    send_frame(14, ETYPE_ARP, 8'h00, 8'h00, 0);
    send_read(3'(CAT_ARP));
    send_read(3'(CAT_MISC));

    while (beats_sent < 550) begin
      if ($urandom_range(9) == 0) send_read(3'($urandom_range(7)));
      send_frame(pick_len(), pick_etype(), pick_proto(), pick_proto(), 8);
    end
    for (int i = 0; i < 8; i++) send_read(3'(i));
    s_axis_tvalid <= 1'b0;

    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #800000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/epcc_pkg.sv
rtl/epcc_classify.sv
rtl/epcc_counters.sv
rtl/ethernet_protocol_class_counter.sv
test/tb_ethernet_protocol_class_counter.sv
